// File: hdl/kmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared types and constants for the keypad matrix debounce core.
// ----------------------------------------------------------------------------
package kmd_pkg;

   localparam int NUM_COLUMNS = 4;
   localparam int NUM_ROWS    = 3;
   localparam int KEY_COUNT   = NUM_COLUMNS * NUM_ROWS;
   localparam int COL_W       = 2;
   localparam int ROW_W       = 3;
   localparam int TIME_W      = 32;
   localparam int BOUNCE_W    = 8;

   localparam logic [BOUNCE_W-1:0] BOUNCE_RESET = 8'd5;

   typedef enum logic [0:0] {
      OP_TICK   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] rows;
   } req_type;

   typedef struct packed {
      logic [KEY_COUNT-1:0] keys;
      logic [KEY_COUNT-1:0] changed;
   } rsp_type;

   // result of one processed transaction, handed to the output register
   typedef struct packed {
      logic    emits;
      rsp_type data;
   } result_type;

endpackage

// File: hdl/kmd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_in_stage
// Input register: holds one request transaction until the datapath takes it.
// ----------------------------------------------------------------------------
module kmd_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kmd_pkg::req_type req_data,
   input  logic             advance,
   output logic             item_valid,
   output kmd_pkg::req_type item
);

   logic             valid_ff;
   logic             valid_in;
   kmd_pkg::req_type data_ff;
   kmd_pkg::req_type data_in;
   logic             load;

   assign req_ready  = !valid_ff || advance;
   assign load       = req_valid && req_ready;
   assign item_valid = valid_ff;
   assign item       = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// File: hdl/kmd_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_debounce
// Tick counter, scan accumulator, held key state and per-key lockout timers.
// ----------------------------------------------------------------------------
module kmd_debounce (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [kmd_pkg::BOUNCE_W-1:0]     csr_wr_data,
   input  logic                             fire,
   input  kmd_pkg::req_type                 item,
   output kmd_pkg::result_type              result
);

   localparam int KEYS = kmd_pkg::KEY_COUNT;
   localparam int TW   = kmd_pkg::TIME_W;

   logic [kmd_pkg::BOUNCE_W-1:0] bounce_ff;
   logic [TW-1:0]                time_ff;
   logic [TW-1:0]                time_in;
   logic [TW-1:0]                lockout_ff [KEYS];
   logic [TW-1:0]                lockout_in [KEYS];
   logic [KEYS-1:0]              held_ff;
   logic [KEYS-1:0]              held_in;
   logic [KEYS-1:0]              accum_ff;
   logic [KEYS-1:0]              accum_in;

   logic                         is_sample;
   logic                         last_col;
   logic                         emits;
   logic [KEYS-1:0]              sample_bits;
   logic [KEYS-1:0]              merged;
   logic [KEYS-1:0]              diff;
   logic [KEYS-1:0]              old_enough;
   logic [KEYS-1:0]              accepted;
   logic [TW-1:0]                elapsed [KEYS];

   assign is_sample = (item.op == kmd_pkg::OP_SAMPLE);
   assign last_col  = (item.col == kmd_pkg::COL_W'(kmd_pkg::NUM_COLUMNS - 1));
   assign emits     = is_sample && last_col;

   // place this column's row levels at bit col*rows+row
   always_comb begin
      sample_bits = '0;
      for (int c = 0; c < kmd_pkg::NUM_COLUMNS; c++) begin
         for (int r = 0; r < kmd_pkg::NUM_ROWS; r++) begin
            sample_bits[c*kmd_pkg::NUM_ROWS + r] =
               is_sample && (item.col == kmd_pkg::COL_W'(c)) && item.rows[r];
         end
      end
   end

   assign merged = accum_ff | sample_bits;
   assign diff   = (~merged) ^ held_ff;

   // elapsed time wraps modulo 2^32
   always_comb begin
      for (int k = 0; k < KEYS; k++) begin
         elapsed[k]    = time_ff - lockout_ff[k];
         old_enough[k] = (elapsed[k] >= TW'(bounce_ff));
      end
   end

   assign accepted = emits ? (diff & old_enough) : '0;

   assign result.emits        = emits;
   assign result.data.keys    = held_ff ^ accepted;
   assign result.data.changed = accepted;

   always_comb begin
      time_in  = time_ff;
      accum_in = accum_ff;
      held_in  = held_ff;
      for (int k = 0; k < KEYS; k++) begin
         lockout_in[k] = lockout_ff[k];
      end
      if (fire) begin
         if (!is_sample) begin
            time_in = time_ff + TW'(1);
         end else if (emits) begin
            accum_in = '0;
            held_in  = held_ff ^ accepted;
            for (int k = 0; k < KEYS; k++) begin
               if (accepted[k]) begin
                  lockout_in[k] = time_ff;
               end
            end
         end else begin
            accum_in = merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bounce_ff <= kmd_pkg::BOUNCE_RESET;
         time_ff   <= '0;
         held_ff   <= '0;
         accum_ff  <= '0;
         for (int k = 0; k < KEYS; k++) begin
            lockout_ff[k] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            bounce_ff <= csr_wr_data;
         end
         time_ff  <= time_in;
         held_ff  <= held_in;
         accum_ff <= accum_in;
         for (int k = 0; k < KEYS; k++) begin
            lockout_ff[k] <= lockout_in[k];
         end
      end
   end

endmodule

// File: hdl/kmd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_out_reg
// Result register on the response channel.
// ----------------------------------------------------------------------------
module kmd_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  kmd_pkg::rsp_type load_data,
   output logic             space,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kmd_pkg::rsp_type rsp_data
);

   logic             valid_ff;
   logic             valid_in;
   kmd_pkg::rsp_type data_ff;
   kmd_pkg::rsp_type data_in;

   assign space     = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// File: hdl/keypad_matrix_debounce_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_matrix_debounce_core
// Response path: the last column's sample passes through the input register
// and then the response register, which presents the response.
// Throughput: one request per cycle; the input register stalls only while it
// holds a last-column sample and the response register is still full.
// Reset (synchronous): clears the tick counter, lockout timers, held keys and
// scan accumulator, and sets the bounce setting to 5 ticks.
// ----------------------------------------------------------------------------
module keypad_matrix_debounce_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  kmd_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output kmd_pkg::rsp_type             rsp_data,
   input  logic                         csr_wr_en,
   input  logic [kmd_pkg::BOUNCE_W-1:0] csr_wr_data
);

   logic                item_valid;
   kmd_pkg::req_type    item;
   kmd_pkg::result_type result;
   logic                out_space;
   logic                advance;

   // a transaction that yields no response never waits on the output side
   assign advance = item_valid && (!result.emits || out_space);

   kmd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   kmd_debounce u_debounce (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (advance),
      .item        (item),
      .result      (result)
   );

   kmd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && result.emits),
      .load_data (result.data),
      .space     (out_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/kmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_checker
// Port-level checks for the keypad matrix debounce core, bound to the top.
// ----------------------------------------------------------------------------
module kmd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input kmd_pkg::req_type             req_data,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input kmd_pkg::rsp_type             rsp_data,
   input logic                         csr_wr_en,
   input logic [kmd_pkg::BOUNCE_W-1:0] csr_wr_data
);

   // response held steady while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed or dropped while stalled");

   // reset leaves both registers empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // requests only ever wait on a full, stalled response register
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled while response side free");

   // a request only ever stalls under response back-pressure
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stall without response back-pressure");

endmodule

bind keypad_matrix_debounce_core kmd_checker u_kmd_checker (.*);

// File: test/keypad_matrix_debounce_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_matrix_debounce_core_tb
// Self-checking bench for the keypad scanner. Column samples and ticks are
// driven through the request channel. A scoreboard tracks time, lockouts and
// held keys, and checks every key-scan response in order. Runs go through
// several bounce settings and handshake idling profiles.
// ----------------------------------------------------------------------------
module keypad_matrix_debounce_core_tb;

   localparam int DRAIN_CYCLES = 4;

   typedef logic [kmd_pkg::KEY_COUNT-1:0] key_vec_type;

   // -------------------------------------------------------------------------
   class key_scan_scoreboard;
      logic [kmd_pkg::BOUNCE_W-1:0] bounce;
      logic [kmd_pkg::TIME_W-1:0]   tick_count;
      logic [kmd_pkg::TIME_W-1:0]   lockout_from [kmd_pkg::KEY_COUNT];
      key_vec_type                  held;
      key_vec_type                  raw_levels;
      kmd_pkg::rsp_type             expected_scans [$];
      int                           errors;

      function new();
         bounce     = kmd_pkg::BOUNCE_RESET;
         tick_count = '0;
         foreach (lockout_from[k]) lockout_from[k] = '0;
         held       = '0;
         raw_levels = '0;
         errors     = 0;
      endfunction

      task report_mismatch(input string what);
         errors++;
         $display("MISMATCH @%0t: %s", $realtime, what);
      endtask

      // predicts the effect of one accepted request transaction
      function void take_request(input kmd_pkg::req_type r);
         key_vec_type                pressed;
         key_vec_type                diff;
         key_vec_type                accepted;
         logic [kmd_pkg::TIME_W-1:0] elapsed;
         kmd_pkg::rsp_type           scan;
         if (r.op == kmd_pkg::OP_TICK) begin
            tick_count++;
            return;
         end
         if (int'(r.col) >= kmd_pkg::NUM_COLUMNS)
            return;
         raw_levels |= key_vec_type'(r.rows) << (int'(r.col) * kmd_pkg::NUM_ROWS);
         if (int'(r.col) != kmd_pkg::NUM_COLUMNS - 1)
            return;
         pressed  = ~raw_levels;
         diff     = pressed ^ held;
         accepted = '0;
         for (int k = 0; k < kmd_pkg::KEY_COUNT; k++) begin
            elapsed = tick_count - lockout_from[k];
            if (diff[k] && elapsed >= kmd_pkg::TIME_W'(bounce)) begin
               accepted[k]     = 1'b1;
               lockout_from[k] = tick_count;
            end
         end
         held          ^= accepted;
         raw_levels     = '0;
         scan.keys      = held;
         scan.changed   = accepted;
         expected_scans.push_back(scan);
      endfunction

      task check_scan_result(input kmd_pkg::rsp_type got);
         kmd_pkg::rsp_type want;
         if (expected_scans.size() == 0) begin
            report_mismatch($sformatf("unexpected response keys=%03h changed=%03h",
                                      got.keys, got.changed));
            return;
         end
         want = expected_scans.pop_front();
         if (got.keys !== want.keys)
            report_mismatch($sformatf("keys %03h, expected %03h", got.keys, want.keys));
         if (got.changed !== want.changed)
            report_mismatch($sformatf("changed %03h, expected %03h",
                                      got.changed, want.changed));
      endtask
   endclass

   // -------------------------------------------------------------------------
   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_valid   = 1'b0;
   logic                         req_ready;
   kmd_pkg::req_type             req_data    = '0;
   logic                         rsp_valid;
   logic                         rsp_ready   = 1'b0;
   kmd_pkg::rsp_type             rsp_data;
   logic                         csr_wr_en   = 1'b0;
   logic [kmd_pkg::BOUNCE_W-1:0] csr_wr_data = '0;

   int                           send_idle_pct = 0;
   int                           recv_idle_pct = 0;
   logic [kmd_pkg::ROW_W-1:0]    row_levels [kmd_pkg::NUM_COLUMNS];

   key_scan_scoreboard           sb = new();

   keypad_matrix_debounce_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_scan_result(rsp_data);
   end

   initial begin
      #2ms;
      $display("DONE: errors detected");
      $finish;
   end

   // -------------------------------------------------------------------------
   // called at a falling edge; returns at the falling edge after acceptance
   task send_request(input kmd_pkg::req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.take_request(r);
      @(negedge clock);
   endtask

   task send_tick();
      kmd_pkg::req_type r;
      r.op   = kmd_pkg::OP_TICK;
      r.col  = kmd_pkg::COL_W'($urandom_range(0, kmd_pkg::NUM_COLUMNS - 1));
      r.rows = kmd_pkg::ROW_W'($urandom_range(0, (1 << kmd_pkg::ROW_W) - 1));
      send_request(r);
   endtask

   task send_sample(input int c, input logic [kmd_pkg::ROW_W-1:0] levels);
      kmd_pkg::req_type r;
      r.op   = kmd_pkg::OP_SAMPLE;
      r.col  = kmd_pkg::COL_W'(c);
      r.rows = levels;
      send_request(r);
   endtask

   task drain_responses();
      req_valid <= 1'b0;
      while (sb.expected_scans.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task write_bounce(input logic [kmd_pkg::BOUNCE_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      sb.bounce = value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task run_directed();
      kmd_pkg::req_type r;
      // all keys pressed straight after reset: held back by the reset lockout
      send_sample(kmd_pkg::NUM_COLUMNS - 1, 3'b000);
      repeat (5) send_tick();
      send_sample(0, 3'b000);
      // same column twice in one scan: levels are ORed
      send_sample(1, 3'b010);
      send_sample(1, 3'b100);
      send_sample(2, 3'b111);
      send_sample(3, 3'b101);
      // tick carrying non-zero column and row fields
      r.op   = kmd_pkg::OP_TICK;
      r.col  = 2'd3;
      r.rows = 3'b111;
      send_request(r);
      // last column alone: unsampled columns read as pressed, still locked out
      send_sample(3, 3'b111);
      repeat (6) send_tick();
      send_sample(3, 3'b111);
      send_sample(0, 3'b111);
      send_sample(1, 3'b111);
      send_sample(2, 3'b111);
      send_sample(3, 3'b111);
   endtask

   task run_random(input int budget);
      int count;
      int choice;
      int burst;
      int burst_max;
      int skip_col;
      count = 0;
      while (count < budget) begin
         choice = $urandom_range(0, 99);
         if (choice < 12) begin
            // noise: any field combination
            send_sample($urandom_range(0, kmd_pkg::NUM_COLUMNS - 1),
                        kmd_pkg::ROW_W'($urandom_range(0, (1 << kmd_pkg::ROW_W) - 1)));
            if ($urandom_range(0, 1)) send_tick();
            count++;
         end else begin
            burst_max = 2 * int'(sb.bounce) + 2;
            if (burst_max > 280) burst_max = 280;
            if ($urandom_range(0, 3) == 0)
               burst = $urandom_range(0, burst_max);
            else
               burst = $urandom_range(0, 3);
            repeat (burst) send_tick();
            count += burst;
            // a few scans are broken by a missing column
            skip_col = (choice < 20) ? $urandom_range(0, kmd_pkg::NUM_COLUMNS - 1) : -1;
            for (int c = 0; c < kmd_pkg::NUM_COLUMNS; c++) begin
               case ($urandom_range(0, 5))
                  0: begin
                     row_levels[c] =
                        kmd_pkg::ROW_W'($urandom_range(0, (1 << kmd_pkg::ROW_W) - 1));
                  end
                  1, 2: begin
                     row_levels[c][$urandom_range(0, kmd_pkg::ROW_W - 1)] ^= 1'b1;
                  end
                  default: ;
               endcase
               if (c != skip_col) begin
                  send_sample(c, row_levels[c]);
                  count++;
               end
            end
         end
      end
   endtask

   // -------------------------------------------------------------------------
   initial begin
      foreach (row_levels[c]) row_levels[c] = '1;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 22;
      recv_idle_pct = 48;
      run_directed();
      drain_responses();
      write_bounce(8'd0);
      run_random(200);
      drain_responses();
      write_bounce(8'd255);
      run_random(300);
      drain_responses();

      send_idle_pct = 48;
      recv_idle_pct = 22;
      write_bounce(8'd1);
      run_random(150);
      // hold the sender off until every response is back
      drain_responses();
      run_random(150);
      drain_responses();
      write_bounce(kmd_pkg::BOUNCE_W'($urandom_range(2, 254)));
      run_random(220);
      drain_responses();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_bounce(8'd3);
      run_random(200);
      drain_responses();
      write_bounce(8'd12);
      run_random(200);
      drain_responses();

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: keypad_matrix_debounce_core.f
hdl/kmd_pkg.sv
hdl/kmd_in_stage.sv
hdl/kmd_debounce.sv
hdl/kmd_out_reg.sv
hdl/keypad_matrix_debounce_core.sv
hdl/kmd_checker.sv
test/keypad_matrix_debounce_core_tb.sv
